### design/bfp_pkg.sv
// shared types, widths and codes of the fat-box pair broadphase
`default_nettype none
package bfp_pkg;

    // store size and number format
    localparam int MAX_BODIES  = 64;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    localparam int IDX_W   = $clog2(MAX_BODIES);
    localparam int COUNT_W = $clog2(MAX_BODIES + 1);

    // fixed field widths
    localparam int IN_W    = 32;
    localparam int STEP_W  = 31;
    localparam int HOR_W   = 16;
    localparam int PAIR_W  = 6;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 31;
    localparam int CFG_A_W = 2;

    // sweep arithmetic widths
    localparam int PROD_W = IN_W + STEP_W;
    localparam int ONE_W  = PROD_W - FRAC_BITS;
    localparam int OFF_W  = ONE_W + HOR_W + 1;
    localparam int FUT_W  = OFF_W + 1;
    localparam int BOX_W  = FUT_W + 1;

    // cycles from item accept until the box registers hold the new box
    localparam int CALC_LAT = 5;
    localparam int CALC_W   = 3;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_HALF_EXTENT    = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_HORIZON_FRAMES = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_DELTA_RAW      = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_PAIR  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // input kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic signed [IN_W-1:0] position_x;
        logic signed [IN_W-1:0] position_y;
        logic signed [IN_W-1:0] velocity_x;
        logic signed [IN_W-1:0] velocity_y;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAIR_W-1:0] pair_low;
        logic [PAIR_W-1:0] pair_high;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] min_x;
        logic signed [COORD_WIDTH-1:0] max_x;
        logic signed [COORD_WIDTH-1:0] min_y;
        logic signed [COORD_WIDTH-1:0] max_y;
    } box_t;

    // broadcast control for the cell row
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### design/bfp_sweep.sv
// per-axis sweep offset: velocity * step / 2^frac, times horizon
`default_nettype none
module bfp_sweep (
    input  wire logic                                clk,
    input  wire logic signed [bfp_pkg::IN_W-1:0]     vel,
    input  wire logic        [bfp_pkg::STEP_W-1:0]   delta,
    input  wire logic        [bfp_pkg::HOR_W-1:0]    horizon,
    output logic signed      [bfp_pkg::OFF_W-1:0]    off
);

    localparam logic [bfp_pkg::PROD_W-1:0] FRAC_MASK =
        bfp_pkg::PROD_W'((64'd1 << bfp_pkg::FRAC_BITS) - 64'd1);

    logic signed [bfp_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [bfp_pkg::PROD_W-1:0] biased;
    logic        [bfp_pkg::PROD_W-1:0] bias;
    logic signed [bfp_pkg::ONE_W-1:0]  one_reg, one_next;
    logic signed [bfp_pkg::OFF_W-1:0]  off_reg, off_next;

    // one frame of displacement, truncated toward zero
    always_comb
    begin
        prod_next = bfp_pkg::PROD_W'(vel)
                    * bfp_pkg::PROD_W'($signed({1'b0, delta}));
        bias      = prod_reg[bfp_pkg::PROD_W-1] ? FRAC_MASK : '0;
        biased    = prod_reg + $signed(bias);
        one_next  = bfp_pkg::ONE_W'(biased >>> bfp_pkg::FRAC_BITS);
        off_next  = bfp_pkg::OFF_W'(one_reg)
                    * bfp_pkg::OFF_W'($signed({1'b0, horizon}));
    end

    // free-running stages
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        one_reg  <= one_next;
        off_reg  <= off_next;
    end

    assign off = off_reg;

endmodule
`default_nettype wire

### design/bfp_cell.sv
// one store slot: holds a box, tests it against the query, passes hit flags down
`default_nettype none
module bfp_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bfp_pkg::cell_ctrl_t ctrl,
    input  wire logic                active,
    input  wire logic                wr,
    input  wire bfp_pkg::box_t       query,
    input  wire logic                hit_in,
    output logic                     hit_out
);

    bfp_pkg::box_t box_reg;
    logic          hit_reg, hit_next;
    logic          overlap;

    // overlap of stored box with query box
    always_comb
    begin
        overlap = (box_reg.min_x <= query.max_x) && (query.min_x <= box_reg.max_x)
               && (box_reg.min_y <= query.max_y) && (query.min_y <= box_reg.max_y);
        hit_next = hit_reg;
        if (ctrl.load)
        begin
            hit_next = active && overlap;
        end
        else if (ctrl.shift)
        begin
            hit_next = hit_in;
        end
    end

    // box storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            box_reg <= query;
        end
    end

    // hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit_out = hit_reg;

endmodule
`default_nettype wire

### design/fat_bound_pair_broadphase_unit.sv
// top level of the fat-box pair broadphase
// Takes one body per item and handles one item at a time. A clear item empties
// the store. An add item passes the sweep pipeline (registered multiply, rounding
// shift, horizon multiply, future position, padded box), then every cell of the
// 64-cell row tests its box at once, and then the hit flags shift toward cell 0
// until the last hit is out, pausing while a hit at cell 0 waits for out_ready.
// Store-full and out-of-range items give one result.
`default_nettype none
module fat_bound_pair_broadphase_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire bfp_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bfp_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_we,
    input  wire logic [bfp_pkg::CFG_A_W-1:0]   cfg_index,
    input  wire logic [bfp_pkg::CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    localparam logic signed [bfp_pkg::BOX_W-1:0] C_MAX =
        {{(bfp_pkg::BOX_W-bfp_pkg::COORD_WIDTH+1){1'b0}},
         {(bfp_pkg::COORD_WIDTH-1){1'b1}}};
    localparam logic signed [bfp_pkg::BOX_W-1:0] C_MIN = ~C_MAX;

    logic [2:0] state_reg, state_next;
    logic [bfp_pkg::CALC_W-1:0]  calc_reg, calc_next;
    logic [bfp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [bfp_pkg::IDX_W-1:0]   scan_reg, scan_next;
    logic [bfp_pkg::STAT_W-1:0]  err_reg, err_next;

    logic [bfp_pkg::CFG_W-1:0]  half_reg;
    logic [bfp_pkg::HOR_W-1:0]  horizon_reg;
    logic [bfp_pkg::STEP_W-1:0] delta_reg;

    logic signed [bfp_pkg::IN_W-1:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [bfp_pkg::COUNT_W-1:0]     new_idx_reg;

    logic signed [bfp_pkg::OFF_W-1:0] off_x, off_y;
    logic signed [bfp_pkg::FUT_W-1:0] fx_reg, fy_reg, pxe_reg, pye_reg;
    logic signed [bfp_pkg::BOX_W-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic signed [bfp_pkg::BOX_W-1:0] half_ext;

    logic               out_valid_reg, out_valid_next;
    bfp_pkg::out_item_t out_reg, out_next;
    logic               out_free;

    bfp_pkg::box_t       query;
    bfp_pkg::cell_ctrl_t ctrl;
    logic                range_bad;
    logic [bfp_pkg::MAX_BODIES-1:0] hit_vec;
    logic                accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= bfp_pkg::CFG_W'(65536);
            horizon_reg <= bfp_pkg::HOR_W'(8);
            delta_reg   <= bfp_pkg::STEP_W'(1092);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfp_pkg::CFG_HALF_EXTENT:    half_reg    <= cfg_data;
                bfp_pkg::CFG_HORIZON_FRAMES: horizon_reg <= cfg_data[bfp_pkg::HOR_W-1:0];
                bfp_pkg::CFG_DELTA_RAW:      delta_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg      <= in_data.position_x;
            py_reg      <= in_data.position_y;
            vx_reg      <= in_data.velocity_x;
            vy_reg      <= in_data.velocity_y;
            new_idx_reg <= count_reg;
        end
    end

    // sweep offsets per axis
    bfp_sweep u_sweep_x (
        .clk     (clk),
        .vel     (vx_reg),
        .delta   (delta_reg),
        .horizon (horizon_reg),
        .off     (off_x)
    );

    bfp_sweep u_sweep_y (
        .clk     (clk),
        .vel     (vy_reg),
        .delta   (delta_reg),
        .horizon (horizon_reg),
        .off     (off_y)
    );

    // future position, then padded box
    assign half_ext = bfp_pkg::BOX_W'($signed({1'b0, half_reg}));

    always_ff @(posedge clk)
    begin
        fx_reg  <= bfp_pkg::FUT_W'(px_reg) + bfp_pkg::FUT_W'(off_x);
        fy_reg  <= bfp_pkg::FUT_W'(py_reg) + bfp_pkg::FUT_W'(off_y);
        pxe_reg <= bfp_pkg::FUT_W'(px_reg);
        pye_reg <= bfp_pkg::FUT_W'(py_reg);
        lo_x_reg <= bfp_pkg::BOX_W'((pxe_reg < fx_reg) ? pxe_reg : fx_reg) - half_ext;
        hi_x_reg <= bfp_pkg::BOX_W'((pxe_reg > fx_reg) ? pxe_reg : fx_reg) + half_ext;
        lo_y_reg <= bfp_pkg::BOX_W'((pye_reg < fy_reg) ? pye_reg : fy_reg) - half_ext;
        hi_y_reg <= bfp_pkg::BOX_W'((pye_reg > fy_reg) ? pye_reg : fy_reg) + half_ext;
    end

    // range check and query box
    always_comb
    begin
        range_bad   = (lo_x_reg < C_MIN) || (hi_x_reg > C_MAX)
                   || (lo_y_reg < C_MIN) || (hi_y_reg > C_MAX);
        query.min_x = bfp_pkg::COORD_WIDTH'(lo_x_reg);
        query.max_x = bfp_pkg::COORD_WIDTH'(hi_x_reg);
        query.min_y = bfp_pkg::COORD_WIDTH'(lo_y_reg);
        query.max_y = bfp_pkg::COORD_WIDTH'(hi_y_reg);
    end

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < bfp_pkg::MAX_BODIES; gi++)
        begin : g_cell
            logic hit_in;
            if (gi == bfp_pkg::MAX_BODIES - 1)
            begin : g_end
                assign hit_in = 1'b0;
            end
            else
            begin : g_mid
                assign hit_in = hit_vec[gi+1];
            end
            bfp_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .active  (bfp_pkg::COUNT_W'(gi) < count_reg),
                .wr      ((state_reg == S_CMP) && !range_bad
                          && (count_reg == bfp_pkg::COUNT_W'(gi))),
                .query   (query),
                .hit_in  (hit_in),
                .hit_out (hit_vec[gi])
            );
        end
    endgenerate

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        calc_next      = calc_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ctrl.load      = 1'b0;
        ctrl.shift     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.kind == bfp_pkg::KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (count_reg == bfp_pkg::COUNT_W'(bfp_pkg::MAX_BODIES))
                    begin
                        err_next   = bfp_pkg::ST_FULL;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        calc_next  = '0;
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                calc_next = calc_reg + 1'b1;
                if (calc_reg == bfp_pkg::CALC_W'(bfp_pkg::CALC_LAT - 1))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (range_bad)
                begin
                    err_next   = bfp_pkg::ST_RANGE;
                    state_next = S_ERR;
                end
                else
                begin
                    ctrl.load  = 1'b1;
                    count_next = count_reg + 1'b1;
                    scan_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (hit_vec == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (!hit_vec[0])
                begin
                    ctrl.shift = 1'b1;
                    scan_next  = scan_reg + 1'b1;
                end
                else if (out_free)
                begin
                    ctrl.shift         = 1'b1;
                    scan_next          = scan_reg + 1'b1;
                    out_valid_next     = 1'b1;
                    out_next.status    = bfp_pkg::ST_PAIR;
                    out_next.pair_low  = bfp_pkg::PAIR_W'(scan_reg);
                    out_next.pair_high = bfp_pkg::PAIR_W'(new_idx_reg);
                    out_next.last      = (hit_vec[bfp_pkg::MAX_BODIES-1:1] == '0);
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.status    = err_reg;
                    out_next.pair_low  = '0;
                    out_next.pair_high = '0;
                    out_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            calc_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            err_reg       <= bfp_pkg::ST_PAIR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            calc_reg      <= calc_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire
